// ===== rtl/core/rrap_pkg.sv =====
// ----------------------------------------------------------------------------
// RADIUS reply attribute parser package
// Shared types and constants for the byte front end, the byte queue and the
// attribute parsing back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rrap_pkg;

   localparam int unsigned POS_W        = 16;
   localparam int unsigned HDR_LEN      = 20;
   localparam int unsigned SVC_TYPE_ATTR = 6;
   localparam int unsigned SVC_ATTR_LEN = 6;
   localparam int unsigned FIFO_DEPTH   = 4;
   localparam int unsigned FIFO_PTR_W   = 2;
   localparam int unsigned FIFO_CNT_W   = 3;

   typedef enum logic [2:0] {
      ST_OK               = 3'd0,
      ST_TRUNCATED        = 3'd1,
      ST_LENGTH_INVALID   = 3'd2,
      ST_ATTR_TRUNCATED   = 3'd3,
      ST_ATTR_LEN_INVALID = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      AE_NONE        = 2'd0,
      AE_TRUNCATED   = 2'd1,
      AE_LEN_INVALID = 2'd2
   } attr_error_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_last;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  reply_code;
      logic [7:0]  reply_id;
      logic [15:0] declared_length;
      logic [12:0] packet_bytes;
      logic        service_found;
      logic [31:0] service_type;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]       rx_byte;
      logic             is_last;
      logic             keep;
      logic [POS_W-1:0] pos;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/rrap_front.sv =====
// ----------------------------------------------------------------------------
// RADIUS reply parser byte front end
// Accepts packet bytes, counts them, marks bytes beyond the receive buffer
// size as dropped and pushes each transaction into the byte queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rrap_front
   import rrap_pkg::*;
#(
   parameter int unsigned MAX_PACKET = 4096
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   input  wire fifo_status_type fifo_status,
   output logic                 push,
   output entry_type            push_entry
);

   logic [POS_W-1:0] count_ff;
   logic [POS_W-1:0] count_in;
   logic             keep;

   assign req_stall = fifo_status.full;
   assign push      = req_valid && !fifo_status.full;
   assign keep      = (count_ff < POS_W'(MAX_PACKET));

   assign push_entry.rx_byte = req_payload.rx_byte;
   assign push_entry.is_last = req_payload.is_last;
   assign push_entry.keep    = keep;
   assign push_entry.pos     = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (req_payload.is_last) begin
            count_in = '0;
         end else if (keep) begin
            count_in = count_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rrap_fifo.sv =====
// ----------------------------------------------------------------------------
// RADIUS reply parser byte queue
// A short first-in first-out queue that decouples the byte front end from
// the attribute parsing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rrap_fifo
   import rrap_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   input  wire logic       pop,
   output entry_type       head,
   output fifo_status_type fifo_status
);

   entry_type             mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic [FIFO_CNT_W-1:0] count_in;

   assign fifo_status.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign fifo_status.empty = (count_ff == '0);
   assign head              = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("byte queue holds more entries than its depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("byte queue popped while empty");

endmodule

`default_nettype wire

// ===== rtl/core/rrap_back.sv =====
// ----------------------------------------------------------------------------
// RADIUS reply parser attribute back end
// Captures the header fields, walks the attributes, keeps the first
// four-byte Service-Type value and registers one result per packet.
// ----------------------------------------------------------------------------
`default_nettype none

module rrap_back
   import rrap_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire entry_type       head,
   input  wire fifo_status_type fifo_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   logic [15:0]    length_ff, length_in, length_upd;
   logic [7:0]     code_ff, code_in, code_upd;
   logic [7:0]     id_ff, id_in, id_upd;
   logic [15:0]    nas_ff, nas_in, nas_upd;
   logic [7:0]     type_ff, type_in, type_upd;
   logic [7:0]     alen_ff, alen_in, alen_upd;
   logic [31:0]    shift_ff, shift_in, shift_upd;
   attr_error_type attr_error_ff, attr_error_in, attr_error_upd;
   logic           svc_hit_ff, svc_hit_in, svc_hit_upd;
   logic [31:0]    svc_value_ff, svc_value_in, svc_value_upd;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            out_free;
   logic [16:0]     pos17, nas17, len17;
   logic [15:0]     count_after;
   status_type      status;
   logic            found;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pop         = !fifo_status.empty && (!head.is_last || out_free);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign pos17 = {1'b0, head.pos};
   assign nas17 = {1'b0, nas_ff};
   assign len17 = {1'b0, length_upd};

   always_comb begin
      code_upd       = code_ff;
      id_upd         = id_ff;
      length_upd     = length_ff;
      nas_upd        = nas_ff;
      type_upd       = type_ff;
      alen_upd       = alen_ff;
      shift_upd      = shift_ff;
      attr_error_upd = attr_error_ff;
      svc_hit_upd    = svc_hit_ff;
      svc_value_upd  = svc_value_ff;
      if (pop && head.keep) begin
         case (head.pos)
            16'd0:   code_upd = head.rx_byte;
            16'd1:   id_upd = head.rx_byte;
            16'd2:   length_upd = {head.rx_byte, length_ff[7:0]};
            16'd3:   length_upd = {length_ff[15:8], head.rx_byte};
            default: length_upd = length_ff;
         endcase
         if (head.pos >= 16'(HDR_LEN) && head.pos < length_upd
             && attr_error_ff == AE_NONE) begin
            if (pos17 == nas17) begin
               if (pos17 + 17'd2 > len17) begin
                  attr_error_upd = AE_TRUNCATED;
               end else begin
                  type_upd = head.rx_byte;
               end
            end else if (pos17 == nas17 + 17'd1) begin
               if (head.rx_byte < 8'd2 || nas17 + {9'd0, head.rx_byte} > len17) begin
                  attr_error_upd = AE_LEN_INVALID;
               end else begin
                  alen_upd  = head.rx_byte;
                  shift_upd = '0;
                  if (head.rx_byte == 8'd2) begin
                     nas_upd = nas_ff + 16'd2;
                  end
               end
            end else begin
               shift_upd = {shift_ff[23:0], head.rx_byte};
               if (pos17 == nas17 + {9'd0, alen_ff} - 17'd1) begin
                  if (type_ff == 8'(SVC_TYPE_ATTR) && alen_ff == 8'(SVC_ATTR_LEN)
                      && !svc_hit_ff) begin
                     svc_hit_upd   = 1'b1;
                     svc_value_upd = {shift_ff[23:0], head.rx_byte};
                  end
                  nas_upd = nas_ff + {8'd0, alen_ff};
               end
            end
         end
      end
   end

   always_comb begin
      count_after = head.keep ? head.pos + 16'd1 : head.pos;
      if (count_after < 16'(HDR_LEN)) begin
         status = ST_TRUNCATED;
      end else if (length_upd < 16'(HDR_LEN) || length_upd > count_after) begin
         status = ST_LENGTH_INVALID;
      end else if (attr_error_upd == AE_TRUNCATED) begin
         status = ST_ATTR_TRUNCATED;
      end else if (attr_error_upd == AE_LEN_INVALID) begin
         status = ST_ATTR_LEN_INVALID;
      end else begin
         status = ST_OK;
      end
      found = (status == ST_OK) && svc_hit_upd;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (pop && head.is_last) begin
         rsp_valid_in           = 1'b1;
         rsp_in.status          = status;
         rsp_in.reply_code      = code_upd;
         rsp_in.reply_id        = id_upd;
         rsp_in.declared_length = length_upd;
         rsp_in.packet_bytes    = count_after[12:0];
         rsp_in.service_found   = found;
         rsp_in.service_type    = found ? svc_value_upd : 32'd0;
      end
   end

   always_comb begin
      if (pop && head.is_last) begin
         code_in       = '0;
         id_in         = '0;
         length_in     = '0;
         nas_in        = 16'(HDR_LEN);
         type_in       = '0;
         alen_in       = '0;
         shift_in      = '0;
         attr_error_in = AE_NONE;
         svc_hit_in    = 1'b0;
         svc_value_in  = '0;
      end else begin
         code_in       = code_upd;
         id_in         = id_upd;
         length_in     = length_upd;
         nas_in        = nas_upd;
         type_in       = type_upd;
         alen_in       = alen_upd;
         shift_in      = shift_upd;
         attr_error_in = attr_error_upd;
         svc_hit_in    = svc_hit_upd;
         svc_value_in  = svc_value_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff       <= '0;
         id_ff         <= '0;
         length_ff     <= '0;
         nas_ff        <= 16'(HDR_LEN);
         type_ff       <= '0;
         alen_ff       <= '0;
         shift_ff      <= '0;
         attr_error_ff <= AE_NONE;
         svc_hit_ff    <= 1'b0;
         svc_value_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         code_ff       <= code_in;
         id_ff         <= id_in;
         length_ff     <= length_in;
         nas_ff        <= nas_in;
         type_ff       <= type_in;
         alen_ff       <= alen_in;
         shift_ff      <= shift_in;
         attr_error_ff <= attr_error_in;
         svc_hit_ff    <= svc_hit_in;
         svc_value_ff  <= svc_value_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_found_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.service_found) |-> (rsp_ff.status == ST_OK))
      else $error("Service-Type reported on a failed packet");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (pop && head.is_last) |=> (nas_ff == 16'(HDR_LEN) && !svc_hit_ff
                                 && attr_error_ff == AE_NONE))
      else $error("parser state not cleared after the last byte");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (attr_error_ff != AE_NONE && !(pop && head.is_last))
      |=> (attr_error_ff != AE_NONE))
      else $error("attribute error cleared within a packet");

endmodule

`default_nettype wire

// ===== rtl/core/radius_reply_attribute_parser_core.sv =====
// ----------------------------------------------------------------------------
// RADIUS reply attribute parser
// Parses one RADIUS reply packet per run of bytes, checks header and
// attribute lengths and extracts the first four-byte Service-Type value.
//
//   Channel  Direction  Payload            Transaction
//   req_     in         rx_byte, is_last   one packet byte
//   rsp_     out        status .. service  one result per packet
//
// One byte is taken per cycle while req_stall is low; a byte passes the front
// counter, the four-entry byte queue and the back parser, and the result is
// registered when the back parser pops the last byte from the queue.
// The back parser's per-byte attribute update sets the one-byte-per-cycle rate.
// Reset is synchronous and clears all counters, the queue and the parser.
// A stalled result holds the back end only at the next last byte; other bytes
// keep flowing until the queue fills, and then req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module radius_reply_attribute_parser_core
   import rrap_pkg::*;
#(
   parameter int unsigned MAX_PACKET = 4096
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   fifo_status_type fifo_status;
   logic            push;
   logic            pop;
   entry_type       push_entry;
   entry_type       head;

   rrap_front #(
      .MAX_PACKET (MAX_PACKET)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   rrap_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .pop         (pop),
      .head        (head),
      .fifo_status (fifo_status)
   );

   rrap_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== bench/tb_radius_reply_attribute_parser_core.sv =====
// ----------------------------------------------------------------------------
// RADIUS reply attribute parser testbench
// Drives reply packets byte by byte into the parser and checks every result
// against a cycle-free model of the header, length and attribute walk. Covers
// directed header and attribute errors, Service-Type extraction, an oversize
// packet, output backpressure and random traffic under several idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_radius_reply_attribute_parser_core;
   import rrap_pkg::*;

   localparam int MAX_PACKET     = 4096;
   localparam int HALF_PERIOD    = 4;
   localparam int BACKLOG_CYCLES = 400;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_BYTES    = 475;
   localparam int RUN_LIMIT_NS   = 5_000_000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   radius_reply_attribute_parser_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Predicted parser state.
   logic [12:0]    seen_bytes;
   logic [15:0]    decl_len;
   logic [7:0]     code_seen;
   logic [7:0]     ident_seen;
   logic [12:0]    attr_start;
   logic [7:0]     attr_kind;
   logic [7:0]     attr_len;
   logic [31:0]    value_acc;
   attr_error_type walk_error;
   logic           svc_seen;
   logic [31:0]    svc_word;

   rsp_payload_type expected_replies[$];
   logic [7:0]      reply_bytes[$];
   int              attr_offsets[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;
   int sent_bytes = 0;
   int packets_sent = 0;
   int replies_checked = 0;

   event backlog_go;
   logic backlog_hold = 1'b0;

   task automatic clear_parser();
      seen_bytes = '0;
      decl_len   = '0;
      code_seen  = '0;
      ident_seen = '0;
      attr_start = 13'(HDR_LEN);
      attr_kind  = '0;
      attr_len   = '0;
      value_acc  = '0;
      walk_error = AE_NONE;
      svc_seen   = 1'b0;
      svc_word   = '0;
   endtask

   task automatic parse_reply_byte(input int pos, input logic [7:0] b);
      int start_pos;
      int limit;
      case (pos)
         0: code_seen = b;
         1: ident_seen = b;
         2: decl_len[15:8] = b;
         3: decl_len[7:0] = b;
         default: ;
      endcase
      start_pos = attr_start;
      limit = decl_len;
      if (pos >= HDR_LEN && pos < limit && walk_error == AE_NONE) begin
         if (pos == start_pos) begin
            if (pos + 2 > limit) walk_error = AE_TRUNCATED;
            else attr_kind = b;
         end else if (pos == start_pos + 1) begin
            if (b < 2 || start_pos + b > limit) begin
               walk_error = AE_LEN_INVALID;
            end else begin
               attr_len = b;
               value_acc = '0;
               if (b == 2) attr_start = 13'(start_pos + 2);
            end
         end else begin
            value_acc = {value_acc[23:0], b};
            if (pos == start_pos + attr_len - 1) begin
               if (attr_kind == SVC_TYPE_ATTR && attr_len == SVC_ATTR_LEN && !svc_seen) begin
                  svc_seen = 1'b1;
                  svc_word = value_acc;
               end
               attr_start = 13'(start_pos + attr_len);
            end
         end
      end
   endtask

   task automatic track_reply_byte(input logic [7:0] b, input logic last);
      rsp_payload_type want;
      status_type      st;
      if (seen_bytes < MAX_PACKET) begin
         parse_reply_byte(int'(seen_bytes), b);
         seen_bytes = seen_bytes + 13'd1;
      end
      if (last) begin
         if (seen_bytes < HDR_LEN) st = ST_TRUNCATED;
         else if (decl_len < HDR_LEN || decl_len > seen_bytes) st = ST_LENGTH_INVALID;
         else if (walk_error == AE_TRUNCATED) st = ST_ATTR_TRUNCATED;
         else if (walk_error == AE_LEN_INVALID) st = ST_ATTR_LEN_INVALID;
         else st = ST_OK;
         want.status          = st;
         want.reply_code      = code_seen;
         want.reply_id        = ident_seen;
         want.declared_length = decl_len;
         want.packet_bytes    = seen_bytes;
         want.service_found   = (st == ST_OK) && svc_seen;
         want.service_type    = want.service_found ? svc_word : 32'd0;
         expected_replies.insert(expected_replies.size(), want);
         clear_parser();
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_payload <= '{rx_byte: b, is_last: last};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_reply_byte(b, last);
      sent_bytes++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_reply();
      for (int i = 0; i < reply_bytes.size(); i++) begin
         send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
      end
      if (reply_bytes.size() != 0) packets_sent++;
   endtask

   task automatic drain_replies();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_replies.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_replies.size() != 0) begin
         $error("%0d expected replies never arrived", expected_replies.size());
         error_count++;
         expected_replies.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic append_byte(input logic [7:0] b);
      reply_bytes.insert(reply_bytes.size(), b);
   endtask

   task automatic start_reply(input logic [7:0] code, input logic [7:0] ident);
      reply_bytes.delete();
      attr_offsets.delete();
      append_byte(code);
      append_byte(ident);
      append_byte(8'h00);
      append_byte(8'h00);
      repeat (16) append_byte(8'($urandom_range(255)));
   endtask

   task automatic add_attr(input logic [7:0] kind, input logic [7:0] len);
      attr_offsets.insert(attr_offsets.size(), reply_bytes.size());
      append_byte(kind);
      append_byte(len);
      for (int i = 2; i < len; i++) append_byte(8'($urandom_range(255)));
   endtask

   task automatic add_service(input logic [31:0] value);
      attr_offsets.insert(attr_offsets.size(), reply_bytes.size());
      append_byte(8'(SVC_TYPE_ATTR));
      append_byte(8'(SVC_ATTR_LEN));
      for (int i = 3; i >= 0; i--) append_byte(value[8*i +: 8]);
   endtask

   task automatic set_length(input int len);
      reply_bytes[2] = 8'(len >> 8);
      reply_bytes[3] = 8'(len);
   endtask

   task automatic seal_length();
      set_length(reply_bytes.size());
   endtask

   task automatic build_random_reply();
      int         pick;
      int         idx;
      logic [7:0] code;
      pick = $urandom_range(99);
      if (pick >= 92) begin
         reply_bytes.delete();
         attr_offsets.delete();
         repeat ($urandom_range(40, 1)) append_byte(8'($urandom_range(255)));
         return;
      end
      case ($urandom_range(3))
         0: code = 8'd2;
         1: code = 8'd3;
         2: code = 8'd11;
         default: code = 8'($urandom_range(255));
      endcase
      start_reply(code, 8'($urandom_range(255)));
      repeat ($urandom_range(4)) begin
         if ($urandom_range(2) == 0) begin
            if ($urandom_range(3) != 0) add_service($urandom());
            else add_attr(8'(SVC_TYPE_ATTR), 8'($urandom_range(9, 2)));
         end else begin
            add_attr(8'($urandom_range(255)), 8'($urandom_range(10, 2)));
         end
      end
      seal_length();
      if (pick < 55) begin
      end else if (pick < 62) begin
         repeat ($urandom_range(6, 1)) append_byte(8'($urandom_range(255)));
      end else if (pick < 69) begin
         repeat ($urandom_range(reply_bytes.size() - 1, 1)) void'(reply_bytes.pop_back());
      end else if (pick < 76) begin
         if ($urandom_range(1) == 0) set_length($urandom_range(65535));
         else set_length($urandom_range(reply_bytes.size() + 4));
      end else if (attr_offsets.size() != 0) begin
         idx = attr_offsets[$urandom_range(attr_offsets.size() - 1)];
         if (pick < 80) reply_bytes[idx + 1] = 8'($urandom_range(1));
         else if (pick < 84) reply_bytes[idx + 1] = 8'($urandom_range(255));
         else set_length(idx + $urandom_range(3, 1));
      end
   endtask

   task automatic test_header_checks();
      reply_bytes = '{8'hFF};
      send_reply();
      start_reply(8'd2, 8'h00);
      void'(reply_bytes.pop_back());
      send_reply();
      start_reply(8'd2, 8'h01);
      seal_length();
      send_reply();
      start_reply(8'd3, 8'hFF);
      set_length(19);
      send_reply();
      start_reply(8'd11, 8'h02);
      set_length(30);
      send_reply();
      start_reply(8'hFF, 8'h03);
      set_length(16'hFFFF);
      send_reply();
   endtask

   task automatic test_attribute_checks();
      start_reply(8'd2, 8'h10);
      append_byte(8'(SVC_TYPE_ATTR));
      seal_length();
      send_reply();
      start_reply(8'd2, 8'h11);
      add_attr(8'(SVC_TYPE_ATTR), 8'd6);
      reply_bytes[21] = 8'd1;
      seal_length();
      send_reply();
      start_reply(8'd2, 8'h12);
      add_attr(8'd1, 8'd4);
      reply_bytes[21] = 8'd0;
      seal_length();
      send_reply();
      start_reply(8'd2, 8'h13);
      add_attr(8'd1, 8'd10);
      set_length(reply_bytes.size() - 3);
      send_reply();
      start_reply(8'd2, 8'h14);
      add_service(32'h0BAD_F00D);
      add_attr(8'd1, 8'd4);
      reply_bytes[reply_bytes.size() - 3] = 8'd255;
      seal_length();
      send_reply();
      drain_replies();
   endtask

   task automatic test_service_extraction();
      start_reply(8'd2, 8'h20);
      add_service(32'hFFFF_FFFF);
      seal_length();
      send_reply();
      start_reply(8'd2, 8'h21);
      add_attr(8'd1, 8'd2);
      add_attr(8'(SVC_TYPE_ATTR), 8'd5);
      add_attr(8'(SVC_TYPE_ATTR), 8'd7);
      add_service(32'h0000_0001);
      add_service(32'h1234_5678);
      seal_length();
      send_reply();
      start_reply(8'd11, 8'h22);
      add_service(32'h8000_0000);
      seal_length();
      repeat (5) append_byte(8'($urandom_range(255)));
      send_reply();
      start_reply(8'd2, 8'h23);
      add_attr(8'hFF, 8'd6);
      seal_length();
      send_reply();
      drain_replies();
   endtask

   task automatic test_oversize_packet();
      start_reply(8'd2, 8'h30);
      add_service(32'h0000_0002);
      repeat (15) add_attr(8'd26, 8'd255);
      add_attr(8'd26, 8'(MAX_PACKET - 20 - 6 - 15 * 255));
      seal_length();
      repeat (4) append_byte(8'($urandom_range(255)));
      send_reply();
      drain_replies();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> backlog_go;
      for (int n = 0; n < 3; n++) begin
         start_reply(8'd2, 8'(8'h40 + n));
         seal_length();
         send_reply();
      end
      req_valid <= 1'b0;
      while (backlog_hold) @(posedge clock);
      drain_replies();
   endtask

   task automatic run_traffic_phase(input int idle_pct, input int stall_pct);
      int first_byte;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_byte = sent_bytes;
      while (sent_bytes - first_byte < PHASE_BYTES) begin
         build_random_reply();
         send_reply();
      end
      drain_replies();
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(0, 0);
      run_traffic_phase(83, 0);
      run_traffic_phase(0, 83);
      run_traffic_phase(9, 9);
   endtask

   always begin
      @(backlog_go);
      backlog_hold <= 1'b1;
      repeat (BACKLOG_CYCLES) @(posedge clock);
      backlog_hold <= 1'b0;
   end

   always @(posedge clock) begin : reply_check
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_payload;
         if (expected_replies.size() == 0) begin
            $error("unexpected reply: status %0d code %0d", got.status, got.reply_code);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            replies_checked++;
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               error_count++;
            end
            if (got.reply_code !== want.reply_code) begin
               $error("reply_code: expected %0d, got %0d", want.reply_code, got.reply_code);
               error_count++;
            end
            if (got.reply_id !== want.reply_id) begin
               $error("reply_id: expected %0d, got %0d", want.reply_id, got.reply_id);
               error_count++;
            end
            if (got.declared_length !== want.declared_length) begin
               $error("declared_length: expected %0d, got %0d",
                      want.declared_length, got.declared_length);
               error_count++;
            end
            if (got.packet_bytes !== want.packet_bytes) begin
               $error("packet_bytes: expected %0d, got %0d", want.packet_bytes, got.packet_bytes);
               error_count++;
            end
            if (got.service_found !== want.service_found) begin
               $error("service_found: expected %0d, got %0d",
                      want.service_found, got.service_found);
               error_count++;
            end
            if (got.service_type !== want.service_type) begin
               $error("service_type: expected %h, got %h", want.service_type, got.service_type);
               error_count++;
            end
         end
      end
      rsp_stall <= backlog_hold || ($urandom_range(99) < rsp_stall_pct);
   end

   initial begin
      clear_parser();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_checks();
      test_attribute_checks();
      test_service_extraction();
      test_oversize_packet();
      test_output_backpressure();
      test_random_traffic();
      drain_replies();
      $display("Sent %0d bytes in %0d packets, checked %0d replies, %0d mismatches.",
               sent_bytes, packets_sent, replies_checked, error_count);
      $display("Covered header and attribute errors, Service-Type capture, oversize and stalls.");
      if (error_count == 0) begin
         $display("** radius_reply_attribute_parser_core: PASSED **");
      end else begin
         $display("** radius_reply_attribute_parser_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Run timed out with %0d replies outstanding.", expected_replies.size());
      $display("** radius_reply_attribute_parser_core: FAILED **");
      $finish;
   end

endmodule

// ===== radius_reply_attribute_parser_core.f =====
rtl/core/rrap_pkg.sv
rtl/core/rrap_front.sv
rtl/core/rrap_fifo.sv
rtl/core/rrap_back.sv
rtl/core/radius_reply_attribute_parser_core.sv
bench/tb_radius_reply_attribute_parser_core.sv
